>>> src/gdac_pkg.sv
// package with shared constants and types of the gyro delta-angle integrator
`default_nettype none
package gdac_pkg;
  localparam int SENSORS = 3;
  localparam int AXES    = 3;
  localparam int SW      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int AW      = 48;   // angle width
  localparam int RW      = 24;   // rate width
  localparam int PW      = 32;   // period width
  localparam int MW      = 97;   // product accumulator width
  localparam int CW      = 49;   // coning operand width
  localparam int STEPS   = 48;   // serial multiplier / divider steps
  localparam int CNTW    = 6;

  localparam logic [1:0] ACT_INTEGRATE = 2'd0;
  localparam logic [1:0] ACT_PUBLISH   = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  // control of one serial multiply-accumulate lane
  typedef struct packed {
    logic load;   // take new multiplicand and multiplier
    logic clr;    // clear accumulator on load
    logic step;   // one multiplier bit
    logic neg;    // subtract the product
    logic last;   // sign bit weight of the multiplier
  } mac_cmd_t;
endpackage
`default_nettype wire

>>> src/gdac_mac.sv
// bit-serial signed multiply-accumulate lane
`default_nettype none
module gdac_mac (
  input  wire                         clk_i,
  input  wire gdac_pkg::mac_cmd_t     cmd_i,
  input  wire logic [gdac_pkg::MW-1:0]    mcand_i,
  input  wire logic [gdac_pkg::STEPS-1:0] mplier_i,
  output logic [gdac_pkg::MW-1:0]     acc_o
);
  import gdac_pkg::*;

  logic [MW-1:0]    mcand_q;
  logic [STEPS-1:0] mplier_q;
  logic [MW-1:0]    acc_q;
  logic             sub;

  assign sub   = cmd_i.neg ^ cmd_i.last;
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      if (cmd_i.clr) begin
        acc_q <= '0;
      end
    end else if (cmd_i.step) begin
      if (mplier_q[0]) begin
        acc_q <= sub ? (acc_q - mcand_q) : (acc_q + mcand_q);
      end
      mcand_q  <= {mcand_q[MW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[STEPS-1:1]};
    end
  end
endmodule
`default_nettype wire

>>> src/gdac_div6.sv
// bit-serial restoring divider by six
`default_nettype none
module gdac_div6 (
  input  wire                             clk_i,
  input  wire                             load_i,
  input  wire                             step_i,
  input  wire logic [gdac_pkg::STEPS-1:0] dividend_i,
  output logic [gdac_pkg::STEPS-1:0]      quot_o
);
  import gdac_pkg::*;

  logic [STEPS-1:0] num_q;
  logic [STEPS-1:0] quot_q;
  logic [3:0]       rem_q;
  logic [3:0]       trial;
  logic             ge;

  assign trial  = {rem_q[2:0], num_q[STEPS-1]};
  assign ge     = trial >= 4'd6;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q  <= dividend_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (step_i) begin
      num_q  <= {num_q[STEPS-2:0], 1'b0};
      quot_q <= {quot_q[STEPS-2:0], ge};
      rem_q  <= ge ? (trial - 4'd6) : trial;
    end
  end
endmodule
`default_nettype wire

>>> src/gyro_delta_angle_coning_integrator.sv
// top level of the three-axis gyro delta-angle integrator with coning correction
`default_nettype none
// Integrates three-axis gyro rate items for up to SENSORS sensors into Q16.32
// delta-angle accumulators with trapezoidal integration and a coning term.
// An integrate item runs, from acceptance until the block is ready again, a
// bit-serial rate-times-period multiply (run together with the serial divide
// of the previous delta angle by six), a step to form the delta angle and the
// coning operand, two serial cross-product passes, each after its load state,
// and a saturating write-back; the three axes run in parallel lanes. Publish
// and clear items are completed when accepted. A publish result sits in an
// output register; the next item is taken once that register is free or being
// drained. Configuration writes are taken any time.
module gyro_delta_angle_coning_integrator (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave item: rate_x[23:0], rate_y[47:24], rate_z[71:48]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,
  // tuser: action[1:0], sensor_index[3:2]
  input  wire  [3:0]  s_axis_tuser,
  // master item: angle_x[47:0], angle_y[95:48], angle_z[143:96]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [143:0] m_axis_tdata,
  // tuser: out_sensor[1:0], angle_valid[2]
  output logic [2:0]  m_axis_tuser,
  // register write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import gdac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN1, ST_MID, ST_LD2, ST_RUN2, ST_LD3, ST_RUN3, ST_FIN
  } state_e;

  localparam logic [STEPS-1:0] DIV_BIAS = STEPS'(64'd3 + 64'd6 * (64'd1 << 41));
  localparam logic [STEPS-1:0] Q_BIAS   = STEPS'(64'd1 << 41);
  localparam logic signed [65:0] MAX48  = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] MIN48  = -MAX48 - 66'sd1;

  // per sensor state
  logic [AW-1:0] acc_q   [SENSORS][AXES];
  logic [AW-1:0] pda_q   [SENSORS][AXES];
  logic [RW-1:0] prate_q [SENSORS][AXES];
  logic [PW-1:0] period_q [3];

  state_e          state_q;
  logic [CNTW-1:0] cnt_q;
  logic [SW-1:0]   sens_q;
  logic [RW-1:0]   w_q  [AXES];
  logic [AW-1:0]   da_q [AXES];
  logic [CW-1:0]   c_q  [AXES];

  logic        out_valid_q;
  logic [1:0]  out_sensor_q;
  logic [AW-1:0] out_ang_q [AXES];
  logic        out_flag_q;

  // input decode
  logic [1:0]    in_act;
  logic [1:0]    in_sens;
  logic [RW-1:0] in_rate [AXES];
  logic          in_fire;
  logic          sens_ok;
  logic [SW-1:0] in_si;

  assign in_act     = s_axis_tuser[1:0];
  assign in_sens    = s_axis_tuser[3:2];
  assign in_rate[0] = s_axis_tdata[23:0];
  assign in_rate[1] = s_axis_tdata[47:24];
  assign in_rate[2] = s_axis_tdata[71:48];
  assign in_si      = in_sens[SW-1:0];
  assign sens_ok    = 32'(in_sens) < 32'(SENSORS);

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  logic start_int;
  assign start_int = in_fire && sens_ok && (in_act == ACT_INTEGRATE)
                     && (period_q[in_sens] != '0);

  // lane control
  mac_cmd_t        cmd;
  logic            div_load;
  logic            div_step;
  logic            last_step;
  assign last_step = cnt_q == CNTW'(STEPS - 1);

  always_comb begin
    cmd      = '0;
    div_load = 1'b0;
    div_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd.load = start_int;
        cmd.clr  = 1'b1;
        div_load = start_int;
      end
      ST_RUN1: begin
        cmd.step = 1'b1;
        div_step = 1'b1;
      end
      ST_LD2: begin
        cmd.load = 1'b1;
        cmd.clr  = 1'b1;
      end
      ST_RUN2: begin
        cmd.step = 1'b1;
        cmd.last = last_step;
      end
      ST_LD3: begin
        cmd.load = 1'b1;
      end
      ST_RUN3: begin
        cmd.step = 1'b1;
        cmd.neg  = 1'b1;
        cmd.last = last_step;
      end
      default: ;
    endcase
  end

  logic [MW-1:0]    mac_acc  [AXES];
  logic [STEPS-1:0] quot     [AXES];

  for (genvar k = 0; k < AXES; k++) begin : g_lane
    localparam int K1 = (k + 1) % AXES;
    localparam int K2 = (k + 2) % AXES;
    logic signed [RW:0] wsum;
    logic [MW-1:0]      mcand;
    logic [STEPS-1:0]   mplier;
    logic [AW-1:0]      pda;

    assign wsum = $signed({in_rate[k][RW-1], in_rate[k]})
                + $signed({prate_q[in_si][k][RW-1], prate_q[in_si][k]});
    assign pda  = pda_q[in_si][k];

    always_comb begin
      case (state_q)
        ST_LD2: begin
          mcand  = MW'($signed(c_q[K1]));
          mplier = da_q[K2];
        end
        ST_LD3: begin
          mcand  = MW'($signed(c_q[K2]));
          mplier = da_q[K1];
        end
        default: begin
          mcand  = MW'(wsum);
          mplier = STEPS'(period_q[in_sens]);
        end
      endcase
    end

    gdac_mac u_mac (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .mcand_i  (mcand),
      .mplier_i (mplier),
      .acc_o    (mac_acc[k])
    );

    gdac_div6 u_div (
      .clk_i      (clk_i),
      .load_i     (div_load),
      .step_i     (div_step),
      .dividend_i (pda + DIV_BIAS),
      .quot_o     (quot[k])
    );
  end

  // delta angle, coning operand and write-back values
  logic [MW-1:0]    da_round [AXES];
  logic [STEPS-1:0] q_val    [AXES];
  logic [MW-1:0]    cone_rnd [AXES];
  logic signed [65:0] sum    [AXES];
  logic [AW-1:0]    sat_val  [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      da_round[k] = mac_acc[k] + MW'(65536);
      q_val[k]    = quot[k] - Q_BIAS;
      cone_rnd[k] = mac_acc[k] + (MW'(1) << 32);
      sum[k]      = $signed(66'($signed(acc_q[sens_q][k])))
                  + $signed(66'($signed(da_q[k])))
                  + $signed(66'($signed(cone_rnd[k][MW-1:33])));
      if (sum[k] > MAX48) begin
        sat_val[k] = AW'(MAX48);
      end else if (sum[k] < MIN48) begin
        sat_val[k] = AW'(MIN48);
      end else begin
        sat_val[k] = sum[k][AW-1:0];
      end
    end
  end

  // registers of the per sensor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSORS; s++) begin
        for (int k = 0; k < AXES; k++) begin
          acc_q[s][k]   <= '0;
          pda_q[s][k]   <= '0;
          prate_q[s][k] <= '0;
        end
      end
      for (int r = 0; r < 3; r++) begin
        period_q[r] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_index_i != 2'd3) begin
        period_q[cfg_index_i] <= cfg_data_i;
      end
      if (in_fire && sens_ok && in_act == ACT_CLEAR) begin
        for (int k = 0; k < AXES; k++) begin
          acc_q[in_si][k] <= '0;
        end
      end
      if (state_q == ST_FIN) begin
        for (int k = 0; k < AXES; k++) begin
          acc_q[sens_q][k]   <= sat_val[k];
          pda_q[sens_q][k]   <= da_q[k];
          prate_q[sens_q][k] <= w_q[k];
        end
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      sens_q       <= '0;
      out_valid_q  <= 1'b0;
      out_sensor_q <= '0;
      out_flag_q   <= 1'b0;
      for (int k = 0; k < AXES; k++) begin
        w_q[k]       <= '0;
        da_q[k]      <= '0;
        c_q[k]       <= '0;
        out_ang_q[k] <= '0;
      end
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && sens_ok && in_act == ACT_PUBLISH) begin
            out_valid_q  <= 1'b1;
            out_sensor_q <= in_sens;
            out_flag_q   <= period_q[in_sens] != '0;
            for (int k = 0; k < AXES; k++) begin
              out_ang_q[k] <= (period_q[in_sens] != '0) ? acc_q[in_si][k] : '0;
            end
          end
          if (start_int) begin
            state_q <= ST_RUN1;
            cnt_q   <= '0;
            sens_q  <= in_si;
            for (int k = 0; k < AXES; k++) begin
              w_q[k] <= in_rate[k];
            end
          end
        end
        ST_RUN1: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= ST_MID;
          end
        end
        ST_MID: begin
          for (int k = 0; k < AXES; k++) begin
            da_q[k] <= da_round[k][AW+16:17];
            c_q[k]  <= CW'($signed(acc_q[sens_q][k])) + CW'($signed(q_val[k]));
          end
          state_q <= ST_LD2;
        end
        ST_LD2: begin
          cnt_q   <= '0;
          state_q <= ST_RUN2;
        end
        ST_RUN2: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= ST_LD3;
          end
        end
        ST_LD3: begin
          cnt_q   <= '0;
          state_q <= ST_RUN3;
        end
        ST_RUN3: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ang_q[2], out_ang_q[1], out_ang_q[0]};
  assign m_axis_tuser  = {out_flag_q, out_sensor_q};
endmodule
`default_nettype wire
